// File: rtl/page_signature_table_assert.svh
// Assertion macros for the page signature table checker.
// Uses i_clk and i_rst_n of the module that includes this header.
`ifndef PAGE_SIGNATURE_TABLE_ASSERT_SVH
`define PAGE_SIGNATURE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pst_pkg.sv
// Shared types and constants of the page signature table.
// No dependencies.
package pst_pkg;

    localparam int unsigned ADDR_W      = 64;
    localparam int unsigned SIG_FIELD_W = 12;
    localparam int unsigned DELTA_W     = 7;

    // Operation codes of an input transaction
    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    // Row update outcome, from the row logic to the pipeline
    typedef struct packed {
        logic                      wr_en;
        logic                      hit;
        logic [SIG_FIELD_W-1:0]    found_signature;
        logic signed [DELTA_W-1:0] block_delta;
    } t_row_result;

endpackage

// File: rtl/pst_row_mem.sv
// One-port-write, one-port-read row memory with registered read data.
// No dependencies.
module pst_row_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned DW    = 140
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write and registered read; a same-address read returns the old row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pst_addr_split.sv
// Splits a byte address into set index, partial tag and block offset.
// Depends on pst_pkg. Non power-of-two set counts use a radix-2^16 reciprocal divider.
module pst_addr_split
    import pst_pkg::*;
#(
    parameter int unsigned SETS        = 64,
    parameter int unsigned TAG_BITS    = 16,
    parameter int unsigned PAGE_SHIFT  = 12,
    parameter int unsigned BLOCK_SHIFT = 6,
    parameter int unsigned SIG_W       = 12,
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int unsigned OFF_W = (PAGE_SHIFT > BLOCK_SHIFT) ? (PAGE_SHIFT - BLOCK_SHIFT) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_kind,
    input  logic [ADDR_W-1:0]      i_address,
    input  logic [SIG_FIELD_W-1:0] i_new_signature,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_kind                  o_kind,
    output logic [SET_W-1:0]       o_set,
    output logic [TAG_BITS-1:0]    o_tag,
    output logic [OFF_W-1:0]       o_offset,
    output logic [SIG_W-1:0]       o_signature
);

    localparam int unsigned PW = ADDR_W - PAGE_SHIFT;
    localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);

    logic [PW-1:0]         page;
    logic [PAGE_SHIFT-1:0] page_low;
    logic [OFF_W-1:0]      offset;
    logic [SIG_W-1:0]      signature;

    // Fields that need no division
    always_comb begin
        page      = i_address[ADDR_W-1:PAGE_SHIFT];
        page_low  = i_address[PAGE_SHIFT-1:0];
        offset    = OFF_W'(page_low >> BLOCK_SHIFT);
        signature = SIG_W'(i_new_signature);
    end

    if (SETS_POW2) begin : g_pow2
        // Set and tag are plain bit fields of the page number
        always_comb begin
            o_valid     = i_valid;
            o_ready     = i_ready;
            o_kind      = t_kind'(i_kind);
            o_set       = SET_W'(page % SETS);
            o_tag       = TAG_BITS'(page / SETS);
            o_offset    = offset;
            o_signature = signature;
        end
    end else begin : g_div
        localparam int unsigned STEP  = 16;
        localparam int unsigned NSTEP = (PW + STEP - 1) / STEP;
        localparam int unsigned PADW  = NSTEP * STEP;
        localparam int unsigned RW    = $clog2(SETS);
        localparam int unsigned CW    = $clog2(NSTEP);
        localparam int unsigned XW    = RW + STEP;
        localparam int unsigned MW    = XW + 1;
        localparam int unsigned NSH   = 2 * RW + STEP;
        localparam logic [MW-1:0] RECIP =
            MW'(((64'd1 << NSH) + 64'(SETS) - 64'd1) / 64'(SETS));

        logic            r_busy;
        logic            r_done;
        logic [CW-1:0]   r_cnt;
        logic [PADW-1:0] r_quo;
        logic [RW-1:0]   r_rem;
        t_kind           r_kind;
        logic [OFF_W-1:0] r_offset;
        logic [SIG_W-1:0] r_signature;
        logic [PADW-1:0] n_quo;
        logic [RW-1:0]   n_rem;
        logic [XW-1:0]   part;
        logic [XW+MW-1:0] prod;
        logic [STEP-1:0] digit;
        logic [XW-1:0]   back;
        logic            accept;

        // One 16-bit quotient digit per cycle, MSB first; the reciprocal
        // multiply is exact for every partial dividend below SETS * 2^16
        always_comb begin
            part  = {r_rem, r_quo[PADW-1 -: STEP]};
            prod  = (XW + MW)'(part) * (XW + MW)'(RECIP);
            digit = STEP'(prod >> NSH);
            back  = XW'(digit) * XW'(SETS);
            n_rem = RW'(part - back);
            n_quo = {r_quo[PADW-STEP-1:0], digit};
        end

        always_comb begin
            o_ready     = !r_busy && (!r_done || i_ready);
            accept      = i_valid && o_ready;
            o_valid     = r_done;
            o_kind      = r_kind;
            o_set       = SET_W'(r_rem);
            o_tag       = TAG_BITS'(r_quo);
            o_offset    = r_offset;
            o_signature = r_signature;
        end

        // Divider control
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else begin
                if (accept) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end else if (r_busy) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NSTEP - 1)) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_busy && (r_cnt == CW'(NSTEP - 1))) begin
                    r_done <= 1'b1;
                end else if (i_ready) begin
                    r_done <= 1'b0;
                end
            end
        end

        // Dividend, remainder and held transaction fields
        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_quo       <= PADW'(page);
                r_rem       <= '0;
                r_kind      <= t_kind'(i_kind);
                r_offset    <= offset;
                r_signature <= signature;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
            end
        end
    end

endmodule

// File: rtl/pst_row_logic.sv
// Hit detection, victim choice and LRU rank update for one set row.
// Depends on pst_pkg.
module pst_row_logic
    import pst_pkg::*;
#(
    parameter int unsigned WAYS     = 4,
    parameter int unsigned TAG_BITS = 16,
    parameter int unsigned OFF_W    = 6,
    parameter int unsigned SIG_W    = 12,
    localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int unsigned EW     = 1 + RANK_W + TAG_BITS + OFF_W + SIG_W
) (
    input  t_kind                      i_kind,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic [OFF_W-1:0]           i_offset,
    input  logic [SIG_W-1:0]           i_signature,
    input  logic [WAYS-1:0][EW-1:0]    i_row,
    output logic [WAYS-1:0][EW-1:0]    o_row,
    output t_row_result                o_res
);

    // Entry layout, LSB first: signature, offset, tag, rank, valid
    localparam int unsigned OFF_LSB  = SIG_W;
    localparam int unsigned TAG_LSB  = OFF_LSB + OFF_W;
    localparam int unsigned RANK_LSB = TAG_LSB + TAG_BITS;
    localparam int unsigned VAL_BIT  = RANK_LSB + RANK_W;
    localparam int unsigned WI       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned DW_D     = (OFF_W + 1 > DELTA_W) ? (OFF_W + 1) : DELTA_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

    logic [WAYS-1:0]              w_valid;
    logic [WAYS-1:0]              w_match;
    logic [WAYS-1:0]              w_lru;
    logic [WAYS-1:0][RANK_W-1:0]  w_rank;
    logic [WI-1:0]                hit_way;
    logic [WI-1:0]                free_way;
    logic [WI-1:0]                lru_way;
    logic [WI-1:0]                sel_way;
    logic                         any_match;
    logic                         any_free;
    logic                         do_touch;
    logic                         do_fill;
    logic [RANK_W:0]              old_rank;
    logic [EW-1:0]                sel_entry;
    logic [DW_D-1:0]              diff;

    // Per-way compares; valid ranks form a permutation, so LRU has the top rank
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_valid[w] = i_row[w][VAL_BIT];
            w_rank[w]  = i_row[w][RANK_LSB +: RANK_W];
            w_match[w] = w_valid[w] && (i_row[w][TAG_LSB +: TAG_BITS] == i_tag);
            w_lru[w]   = (w_rank[w] == RANK_MAX);
        end
    end

    // Lowest-numbered way wins in each priority pick
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                hit_way = WI'(w);
            end
            if (!w_valid[w]) begin
                free_way = WI'(w);
            end
            if (w_lru[w]) begin
                lru_way = WI'(w);
            end
        end
        any_match = |w_match;
        any_free  = !(&w_valid);
    end

    // Way selection per operation
    always_comb begin
        sel_way  = hit_way;
        do_touch = 1'b0;
        do_fill  = 1'b0;
        case (i_kind)
            KIND_READ: begin
                do_touch = any_match;
            end
            KIND_UPDATE: begin
                sel_way  = any_match ? hit_way : (any_free ? free_way : lru_way);
                do_touch = 1'b1;
                do_fill  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Make the selected way most recent, age the younger valid ways; an update also refills it
    always_comb begin
        sel_entry = i_row[sel_way];
        old_rank  = sel_entry[VAL_BIT] ? {1'b0, sel_entry[RANK_LSB +: RANK_W]}
                                       : (RANK_W + 1)'(WAYS);
        o_row     = i_row;
        if (do_touch) begin
            for (int v = 0; v < WAYS; v++) begin
                if ((WI'(v) != sel_way) && w_valid[v] && ({1'b0, w_rank[v]} < old_rank)
                    && (w_rank[v] < RANK_MAX)) begin
                    o_row[v][RANK_LSB +: RANK_W] = w_rank[v] + 1'b1;
                end
            end
            o_row[sel_way][RANK_LSB +: RANK_W] = '0;
        end
        if (do_fill) begin
            o_row[sel_way] = {1'b1, {RANK_W{1'b0}}, i_tag, i_offset, i_signature};
        end
    end

    // Read result; zero unless a read hit
    always_comb begin
        diff                  = DW_D'(i_offset) - DW_D'(sel_entry[OFF_LSB +: OFF_W]);
        o_res.wr_en           = do_touch;
        o_res.hit             = (i_kind == KIND_READ) && any_match;
        o_res.found_signature = o_res.hit ? SIG_FIELD_W'(sel_entry[SIG_W-1:0]) : '0;
        o_res.block_delta     = o_res.hit ? signed'(diff[DELTA_W-1:0]) : '0;
    end

endmodule

// File: rtl/page_signature_table.sv
// Path: address split, row stage with a registered row memory read, result register;
// for non-power-of-two SETS the address split adds a registered divider stage.
// Throughput: one transaction per cycle for power-of-two SETS while the output is not
// stalled, set by the row memory read-modify-write loop with write-to-read forwarding;
// otherwise the divider takes no new transaction until it hands off the last one.
// Reset clears all control state and the per-set valid flags; a clear operation empties
// the table through the same flags.
module page_signature_table
    import pst_pkg::*;
#(
    parameter int unsigned SETS           = 64,
    parameter int unsigned WAYS           = 4,
    parameter int unsigned TAG_BITS       = 16,
    parameter int unsigned PAGE_SHIFT     = 12,
    parameter int unsigned BLOCK_SHIFT    = 6,
    parameter int unsigned SIGNATURE_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_kind,
    input  logic [ADDR_W-1:0]         i_address,
    input  logic [SIG_FIELD_W-1:0]    i_new_signature,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_hit,
    output logic [SIG_FIELD_W-1:0]    o_found_signature,
    output logic signed [DELTA_W-1:0] o_block_delta
);

    localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned OFF_W  = (PAGE_SHIFT > BLOCK_SHIFT) ? (PAGE_SHIFT - BLOCK_SHIFT) : 1;
    localparam int unsigned SIG_W  = (SIGNATURE_BITS < SIG_FIELD_W) ? SIGNATURE_BITS
                                                                    : SIG_FIELD_W;
    localparam int unsigned EW     = 1 + RANK_W + TAG_BITS + OFF_W + SIG_W;

    // Split stage outputs
    logic                 s_valid;
    logic                 s_ready;
    t_kind                s_kind;
    logic [SET_W-1:0]     s_set;
    logic [TAG_BITS-1:0]  s_tag;
    logic [OFF_W-1:0]     s_offset;
    logic [SIG_W-1:0]     s_signature;

    // Row stage
    logic                        r_busy;
    t_kind                       r_kind;
    logic [SET_W-1:0]            r_set;
    logic [TAG_BITS-1:0]         r_tag;
    logic [OFF_W-1:0]            r_offset;
    logic [SIG_W-1:0]            r_signature;
    logic                        r_fwd;
    logic [WAYS-1:0][EW-1:0]     r_fwd_row;
    logic [SETS-1:0]             r_row_valid;
    logic [WAYS-1:0][EW-1:0]     mem_q;
    logic [WAYS-1:0][EW-1:0]     cur_row;
    logic [WAYS-1:0][EW-1:0]     row_new;
    t_row_result                 res;
    logic                        advance;
    logic                        accept;
    logic                        row_wr;

    // Result register
    logic                        r_out_valid;
    logic                        r_hit;
    logic [SIG_FIELD_W-1:0]      r_found;
    logic signed [DELTA_W-1:0]   r_delta;

    pst_addr_split #(
        .SETS        (SETS),
        .TAG_BITS    (TAG_BITS),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .SIG_W       (SIG_W)
    ) u_split (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_address       (i_address),
        .i_new_signature (i_new_signature),
        .o_valid         (s_valid),
        .i_ready         (s_ready),
        .o_kind          (s_kind),
        .o_set           (s_set),
        .o_tag           (s_tag),
        .o_offset        (s_offset),
        .o_signature     (s_signature)
    );

    // Stage handshake; an unwritten or cleared set reads as an empty row
    always_comb begin
        advance = r_busy && (!r_out_valid || i_ready);
        s_ready = !r_busy || advance;
        accept  = s_valid && s_ready;
        row_wr  = advance && res.wr_en;
        if (r_fwd) begin
            cur_row = r_fwd_row;
        end else if (r_row_valid[r_set]) begin
            cur_row = mem_q;
        end else begin
            cur_row = '0;
        end
    end

    pst_row_mem #(
        .DEPTH (SETS),
        .AW    (SET_W),
        .DW    (WAYS * EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (s_set),
        .o_rd_data (mem_q),
        .i_wr_en   (row_wr),
        .i_wr_addr (r_set),
        .i_wr_data (row_new)
    );

    pst_row_logic #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS),
        .OFF_W    (OFF_W),
        .SIG_W    (SIG_W)
    ) u_logic (
        .i_kind      (r_kind),
        .i_tag       (r_tag),
        .i_offset    (r_offset),
        .i_signature (r_signature),
        .i_row       (cur_row),
        .o_row       (row_new),
        .o_res       (res)
    );

    // Control: stage occupancy, forwarding flag, set valid flags, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fwd       <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                // memory returns the old row when the same set is written this edge
                r_fwd  <= row_wr && (s_set == r_set);
            end else if (advance) begin
                r_busy <= 1'b0;
            end
            if (advance && (r_kind == KIND_CLEAR)) begin
                r_row_valid <= '0;
            end else if (row_wr) begin
                r_row_valid[r_set] <= 1'b1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction fields, bypass row and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= s_kind;
            r_set       <= s_set;
            r_tag       <= s_tag;
            r_offset    <= s_offset;
            r_signature <= s_signature;
            r_fwd_row   <= row_new;
        end
        if (advance) begin
            r_hit   <= res.hit;
            r_found <= res.found_signature;
            r_delta <= res.block_delta;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_hit             = r_hit;
    assign o_found_signature = r_found;
    assign o_block_delta     = r_delta;

endmodule

// File: rtl/pst_checker.sv
// Port-level checks for page_signature_table, bound to every instance.
// Depends on page_signature_table_assert.svh.
`include "page_signature_table_assert.svh"

module pst_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_hit,
    input logic [11:0]       o_found_signature,
    input logic signed [6:0] o_block_delta
);

    logic [2:0] r_pending;
    logic [2:0] n_pending;

    // Transactions taken in but not yet delivered
    always_comb begin
        n_pending = r_pending;
        if (i_valid && o_ready) begin
            n_pending = n_pending + 1'b1;
        end
        if (o_valid && i_ready) begin
            n_pending = n_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `PST_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `PST_ASSERT_IMP(a_no_phantom, o_valid && i_ready, r_pending != 3'd0, "result without transaction")
    `PST_ASSERT_IMP(a_bounded, 1'b1, r_pending <= 3'd3, "too many transactions in flight")
    `PST_ASSERT_IMP(a_miss_zero, o_valid && !o_hit, (o_found_signature == '0) && (o_block_delta == '0), "nonzero fields without hit")

endmodule

bind page_signature_table pst_checker u_pst_checker (.*);

// File: tb/page_signature_table_tb.sv
// Self-checking testbench for page_signature_table: directed and random lookup/update/clear
// traffic checked against an in-bench table model with per-set LRU replacement.
// Depends on pst_pkg and the page_signature_table RTL.
`timescale 1ns / 100ps

module page_signature_table_tb;
    import pst_pkg::*;

    localparam int unsigned SETS           = 64;
    localparam int unsigned WAYS           = 4;
    localparam int unsigned TAG_BITS       = 16;
    localparam int unsigned PAGE_SHIFT     = 12;
    localparam int unsigned BLOCK_SHIFT    = 6;
    localparam int unsigned SIGNATURE_BITS = 12;
    localparam int unsigned ENTRIES        = SETS * WAYS;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         PRINT_LIMIT  = 20;

    // Expected contents of one result transaction
    typedef struct {
        logic                      hit;
        logic [SIG_FIELD_W-1:0]    signature;
        logic signed [DELTA_W-1:0] delta;
    } t_lookup_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_kind = KIND_READ;
    logic [ADDR_W-1:0]         i_address = '0;
    logic [SIG_FIELD_W-1:0]    i_new_signature = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_hit;
    logic [SIG_FIELD_W-1:0]    o_found_signature;
    logic signed [DELTA_W-1:0] o_block_delta;

    page_signature_table #(
        .SETS           (SETS),
        .WAYS           (WAYS),
        .TAG_BITS       (TAG_BITS),
        .PAGE_SHIFT     (PAGE_SHIFT),
        .BLOCK_SHIFT    (BLOCK_SHIFT),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_kind            (i_kind),
        .i_address         (i_address),
        .i_new_signature   (i_new_signature),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_hit             (o_hit),
        .o_found_signature (o_found_signature),
        .o_block_delta     (o_block_delta)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Table model state
    bit                      pg_valid    [ENTRIES];
    logic [TAG_BITS-1:0]     pg_tag      [ENTRIES];
    logic [5:0]              pg_last_off [ENTRIES];
    logic [SIG_FIELD_W-1:0]  pg_sig      [ENTRIES];
    logic [1:0]              pg_rank     [ENTRIES];

    t_lookup_result expected_lookups[$];
    int             mismatch_count = 0;
    int             tx_idle_pct = 0;
    int             rx_stall_pct = 0;
    int             rx_cycle = 0;
    int             rx_hold_until = 0;
    int             stall_cycles = 0;

    function automatic void clear_sig_table();
        for (int e = 0; e < ENTRIES; e++) begin
            pg_valid[e]    = 1'b0;
            pg_tag[e]      = '0;
            pg_last_off[e] = '0;
            pg_sig[e]      = '0;
            pg_rank[e]     = '0;
        end
    endfunction

    // Lowest-numbered valid way holding the tag, or -1
    function automatic int find_page_way(int base, logic [TAG_BITS-1:0] tg);
        for (int w = 0; w < WAYS; w++)
            if (pg_valid[base + w] && pg_tag[base + w] == tg)
                return w;
        return -1;
    endfunction

    // Hit way, else first free way, else least recent (lowest way on a tie)
    function automatic int pick_victim_way(int base, logic [TAG_BITS-1:0] tg);
        int w;
        int best;
        w = find_page_way(base, tg);
        best = 0;
        if (w >= 0)
            return w;
        for (w = 0; w < WAYS; w++)
            if (!pg_valid[base + w])
                return w;
        for (w = 1; w < WAYS; w++)
            if (pg_rank[base + w] > pg_rank[base + best])
                best = w;
        return best;
    endfunction

    // Move a way to most recent; valid ways that were more recent age by one
    function automatic void promote_way(int base, int w);
        int me;
        int old_rank;
        me = base + w;
        old_rank = pg_valid[me] ? int'(pg_rank[me]) : WAYS;
        for (int v = 0; v < WAYS; v++)
            if (v != w && pg_valid[base + v] && int'(pg_rank[base + v]) < old_rank
                    && int'(pg_rank[base + v]) < WAYS - 1)
                pg_rank[base + v] = pg_rank[base + v] + 2'd1;
        pg_rank[me] = '0;
    endfunction

    // Apply one accepted transaction to the model and return the result it yields
    function automatic t_lookup_result sig_table_access(logic [1:0] kind,
                                                        logic [ADDR_W-1:0] addr,
                                                        logic [SIG_FIELD_W-1:0] nsig);
        t_lookup_result      r;
        logic [51:0]         page;
        int                  base;
        int                  w;
        int                  e;
        logic [TAG_BITS-1:0] tg;
        logic [5:0]          off;
        r.hit       = 1'b0;
        r.signature = '0;
        r.delta     = '0;
        page = addr[ADDR_W-1:PAGE_SHIFT];
        base = int'(page[5:0]) * WAYS;
        tg   = page[21:6];
        off  = addr[PAGE_SHIFT-1:BLOCK_SHIFT];
        case (kind)
            KIND_READ: begin
                w = find_page_way(base, tg);
                if (w >= 0) begin
                    e = base + w;
                    r.hit       = 1'b1;
                    r.signature = pg_sig[e];
                    r.delta     = {1'b0, off} - {1'b0, pg_last_off[e]};
                    promote_way(base, w);
                end
            end
            KIND_UPDATE: begin
                w = pick_victim_way(base, tg);
                promote_way(base, w);
                e = base + w;
                pg_valid[e]    = 1'b1;
                pg_tag[e]      = tg;
                pg_last_off[e] = off;
                pg_sig[e]      = nsig;
            end
            KIND_CLEAR: clear_sig_table();
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] make_address(logic [TAG_BITS-1:0] tg, logic [5:0] set,
                                                       logic [5:0] off);
        return {30'h0, tg, set, off, 6'h0};
    endfunction

    // Mostly a small pool of pages (more tags than ways) so hits and evictions happen
    function automatic logic [ADDR_W-1:0] random_page_address();
        logic [ADDR_W-1:0] a;
        a = {$urandom, $urandom};
        if ($urandom_range(99) < 85) begin
            a[17:12] = 6'($urandom_range(0, 3) * 21);
            case ($urandom_range(0, 5))
                0: a[33:18] = 16'h0000;
                1: a[33:18] = 16'hFFFF;
                2: a[33:18] = 16'h0001;
                3: a[33:18] = 16'h8000;
                4: a[33:18] = 16'h5A5A;
                default: a[33:18] = 16'hA5A5;
            endcase
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offer one transaction, wait for it to be taken, then record what it should return
    task automatic send_access(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                               input logic [SIG_FIELD_W-1:0] nsig);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_address       <= addr;
        i_new_signature <= nsig;
        do @(posedge i_clk); while (!o_ready);
        expected_lookups.insert(expected_lookups.size(), sig_table_access(kind, addr, nsig));
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        i_ready  <= (rx_cycle + 1 >= rx_hold_until) && ($urandom_range(99) >= rx_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                want = expected_lookups.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch("hit", o_hit, want.hit);
                if (o_found_signature !== want.signature)
                    report_mismatch("found_signature", o_found_signature, want.signature);
                if (o_block_delta !== want.delta)
                    report_mismatch("block_delta", longint'(o_block_delta),
                                    longint'(want.delta));
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("page_signature_table_tb NOT OK");
            $finish;
        end
    end

    // Extremes, deltas of both signs, tag mismatch, unused kind, LRU eviction, clear
    task automatic test_directed_cases();
        tx_idle_pct = 0;
        send_access(KIND_READ,   '0, '0);
        send_access(KIND_UPDATE, '0, 12'hFFF);
        send_access(KIND_READ,   make_address(16'h0000, 6'd0, 6'd63), '0);
        send_access(KIND_UPDATE, '1, '0);
        send_access(KIND_READ,   64'hFFFF_FFFF_FFFF_F000, 12'hFFF);
        send_access(KIND_READ,   64'hFFFF_FFFF_FFFB_F000, '0);
        send_access(KIND_UNUSED, '1, 12'hFFF);
        send_access(KIND_READ,   '1, '0);
        // fill set 5, refresh tag 1, then a fifth tag evicts tag 2
        for (int t = 1; t <= 4; t++)
            send_access(KIND_UPDATE, make_address(16'(t), 6'd5, 6'(t * 10)), 12'(t * 257));
        send_access(KIND_READ,   make_address(16'd1, 6'd5, 6'd0), '0);
        send_access(KIND_UPDATE, make_address(16'd5, 6'd5, 6'd32), 12'hABC);
        send_access(KIND_READ,   make_address(16'd2, 6'd5, 6'd20), '0);
        send_access(KIND_READ,   make_address(16'd5, 6'd5, 6'd1), '0);
        send_access(KIND_UPDATE, make_address(16'd3, 6'd5, 6'd63), 12'h123);
        send_access(KIND_READ,   make_address(16'd3, 6'd5, 6'd0), '0);
        send_access(KIND_READ,   make_address(16'd4, 6'd5, 6'd40), '0);
        send_access(KIND_CLEAR,  '0, 12'hFFF);
        send_access(KIND_READ,   '1, '0);
        send_access(KIND_READ,   make_address(16'd3, 6'd5, 6'd0), '0);
    endtask

    // Random traffic, mostly insert-then-revisit walks over a page
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int                sent;
        int                roll;
        int                reps;
        logic [ADDR_W-1:0] a;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            a = random_page_address();
            if (roll < 60) begin
                send_access(KIND_UPDATE, a, 12'($urandom));
                reps = $urandom_range(1, 3);
                repeat (reps) begin
                    a[11:0] = 12'($urandom);
                    send_access($urandom_range(99) < 70 ? KIND_READ : KIND_UPDATE, a,
                                12'($urandom));
                end
                sent += 1 + reps;
            end else if (roll < 95) begin
                send_access($urandom_range(1) ? KIND_READ : KIND_UPDATE, a, 12'($urandom));
                sent++;
            end else if (roll < 98) begin
                send_access(KIND_UNUSED, a, 12'($urandom));
            end else begin
                send_access(KIND_CLEAR, a, 12'($urandom));
                sent++;
            end
        end
    endtask

    // Output held off for a long stretch while input keeps coming, so the block backs up
    task automatic test_input_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        rx_hold_until <= rx_cycle + HOLD_CYCLES;
        for (int n = 0; n < 40; n++)
            send_access(n[0] ? KIND_READ : KIND_UPDATE, random_page_address(), 12'($urandom));
    endtask

    initial begin
        clear_sig_table();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(330, 0, 0);
        test_random_traffic(330, 45, 0);
        test_input_backpressure();
        test_random_traffic(330, 0, 45);
        test_random_traffic(330, 26, 26);

        i_valid <= 1'b0;
        rx_stall_pct <= 0;
        while (expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("page_signature_table_tb OK");
        else
            $display("page_signature_table_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_row_mem.sv
rtl/pst_addr_split.sv
rtl/pst_row_logic.sv
rtl/page_signature_table.sv
rtl/pst_checker.sv
tb/page_signature_table_tb.sv
